// ===== design/provisioning_tlv_parser_macros.svh =====
// ----------------------------------------------------------------------------
// Provisioning TLV parser assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef PROVISIONING_TLV_PARSER_MACROS_SVH
`define PROVISIONING_TLV_PARSER_MACROS_SVH

// Same-cycle implication.
`define PTP_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ptp_pkg.sv =====
// ----------------------------------------------------------------------------
// Provisioning TLV parser package
// Payload types, element codes and queue sizing shared by the parser files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptp_pkg;

  // Attribute id bytes
  localparam logic [7:0] ID_SSID        = 8'hF5;
  localparam logic [7:0] ID_PASSWORD    = 8'hF4;
  localparam logic [7:0] ID_BSSID       = 8'hF3;
  localparam logic [7:0] ID_TOKEN       = 8'hF2;
  localparam logic [7:0] ID_REGION_ID   = 8'hEF;
  localparam logic [7:0] ID_URL         = 8'hEE;
  localparam logic [7:0] ID_REGION_TYPE = 8'hED;

  // Element type bytes
  localparam logic [7:0] TYPE_STRING = 8'd11;
  localparam logic [7:0] TYPE_BINARY = 8'd14;
  localparam logic [7:0] TYPE_REGION = 8'd2;

  // Exact BSSID length
  localparam logic [7:0] BSSID_LEN = 8'd6;

  // Attribute codes
  localparam logic [2:0] ATTR_SSID        = 3'd0;
  localparam logic [2:0] ATTR_PASSWORD    = 3'd1;
  localparam logic [2:0] ATTR_BSSID       = 3'd2;
  localparam logic [2:0] ATTR_TOKEN       = 3'd3;
  localparam logic [2:0] ATTR_REGION_ID   = 3'd4;
  localparam logic [2:0] ATTR_URL         = 3'd5;
  localparam logic [2:0] ATTR_REGION_TYPE = 3'd6;
  localparam logic [2:0] ATTR_UNKNOWN     = 3'd7;

  // Result kinds
  localparam logic KIND_VALUE   = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Summary status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;

  // Result queue
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic       first;
    logic [7:0] msg_len;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       kind;
    logic [2:0] attribute;
    logic [7:0] value_byte;
    logic [7:0] value_index;
    logic       value_last;
    logic [1:0] status;
    logic [6:0] ready_flags;
    logic       apinfo_ready;
    logic       last;
  } out_t;

  // Results produced by one parsed byte: none, one or two
  typedef struct packed {
    logic [1:0] cnt;
    out_t       r0;
    out_t       r1;
  } push_t;

endpackage

// ===== design/provisioning_tlv_parser.sv =====
// ----------------------------------------------------------------------------
// Provisioning TLV parser
// Parses a provisioning message byte by byte, streams tagged value bytes and
// closes each message with a status summary.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (ptp_pkg::in_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (ptp_pkg::out_t)
//
// One message byte is taken per cycle while the result queue has room; a byte
// that gives one result keeps that rate, a byte that gives a value and the
// closing summary is bounded by the single read port of the result queue.
// Each byte's results pass through the input register and then the result queue.
// Reset clears the parser state and the queue; the block is idle after reset.
// Output stalls back up through the four-entry queue and the input register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "provisioning_tlv_parser_macros.svh"

module provisioning_tlv_parser #(
  parameter int unsigned SSID_MAX     = 32,
  parameter int unsigned PASSWORD_MAX = 64,
  parameter int unsigned TOKEN_MAX    = 32,
  parameter int unsigned URL_MAX      = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ptp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ptp_pkg::out_t out_data_o
);

  // Input register: holds one byte until the queue has room for its results
  logic           stg_vld_q;
  ptp_pkg::in_t   stg_q;
  logic           fire;
  logic           room2;
  ptp_pkg::push_t push;

  // Advance the held byte when the queue can take two results
  assign fire       = stg_vld_q && room2;
  assign in_ready_o = !stg_vld_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_vld_q <= in_valid_i;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_q <= in_data_i;
    end
  end

  // Parse the held byte against the element state
  ptp_parse_core #(
    .SSID_MAX     (SSID_MAX),
    .PASSWORD_MAX (PASSWORD_MAX),
    .TOKEN_MAX    (TOKEN_MAX),
    .URL_MAX      (URL_MAX)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (stg_q),
    .push_o (push)
  );

  // Queue results; each output transfer drops one entry
  ptp_out_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (out_ready_i),
    .head_o  (out_data_o),
    .avail_o (out_valid_o),
    .room2_o (room2)
  );

  // A value result never carries summary fields
  `PTP_ASSERT_IMPL(a_value_clean,
    out_valid_o && (out_data_o.kind == ptp_pkg::KIND_VALUE),
    (out_data_o.status == ptp_pkg::ST_OK) && (out_data_o.ready_flags == 7'd0) &&
    !out_data_o.apinfo_ready, "value result carries summary fields")

  // A summary always ends its step and reflects the ssid and password flags
  `PTP_ASSERT_IMPL(a_summary_fields,
    out_valid_o && (out_data_o.kind == ptp_pkg::KIND_SUMMARY),
    out_data_o.last && (out_data_o.apinfo_ready == |out_data_o.ready_flags[1:0]),
    "summary result fields inconsistent")

  // A value without last is followed by its summary already queued
  `PTP_ASSERT_NEXT(a_summary_follows,
    out_valid_o && out_ready_i && (out_data_o.kind == ptp_pkg::KIND_VALUE) &&
    !out_data_o.last,
    out_valid_o && (out_data_o.kind == ptp_pkg::KIND_SUMMARY),
    "summary missing after final value byte")

endmodule

// ===== design/ptp_parse_core.sv =====
// ----------------------------------------------------------------------------
// Provisioning TLV parser core
// Per-byte element state machine; emits up to two results per parsed byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptp_parse_core #(
  parameter int unsigned SSID_MAX     = 32,
  parameter int unsigned PASSWORD_MAX = 64,
  parameter int unsigned TOKEN_MAX    = 32,
  parameter int unsigned URL_MAX      = 128
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           fire_i,
  input  ptp_pkg::in_t   item_i,
  output ptp_pkg::push_t push_o
);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhType  = 3'd1;
  localparam logic [2:0] PhAttr  = 3'd2;
  localparam logic [2:0] PhLenHi = 3'd3;
  localparam logic [2:0] PhLenLo = 3'd4;
  localparam logic [2:0] PhValue = 3'd5;

  localparam logic [7:0] SsidLim  = 8'(SSID_MAX);
  localparam logic [7:0] PassLim  = 8'(PASSWORD_MAX);
  localparam logic [7:0] TokenLim = 8'(TOKEN_MAX);
  localparam logic [7:0] UrlLim   = 8'(URL_MAX);

  logic [2:0] phase_q, phase_d;
  logic [7:0] pos_q, pos_d;
  logic [7:0] mlen_q, mlen_d;
  logic [7:0] etype_q, etype_d;
  logic [2:0] attr_q, attr_d;
  logic [7:0] vlen_q, vlen_d;   // length high byte during PhLenLo, else length
  logic [7:0] vcnt_q, vcnt_d;
  logic [6:0] seen_q, seen_d;

  logic [2:0] ph_e;
  logic [7:0] pos_e, mlen_e, etype_e, vlen_e, vcnt_e;
  logic [2:0] attr_e;
  logic [6:0] seen_e;
  logic       active;

  logic        [7:0] b;
  logic signed [9:0] rest;
  logic        [2:0] id_attr;
  logic        [7:0] type_need;
  logic              err;
  logic        [1:0] err_status;
  logic              val_out;
  logic              vlast;
  logic              len_bad;
  logic              attr_bad;
  logic              done;
  ptp_pkg::out_t     val_res, sum_res;

  assign b = item_i.data_byte;

  // A first byte opens a fresh message in the type phase
  always_comb begin
    if (item_i.first) begin
      ph_e    = PhType;
      pos_e   = '0;
      mlen_e  = item_i.msg_len;
      etype_e = '0;
      attr_e  = '0;
      vlen_e  = '0;
      vcnt_e  = '0;
      seen_e  = '0;
    end else begin
      ph_e    = phase_q;
      pos_e   = pos_q;
      mlen_e  = mlen_q;
      etype_e = etype_q;
      attr_e  = attr_q;
      vlen_e  = vlen_q;
      vcnt_e  = vcnt_q;
      seen_e  = seen_q;
    end
  end

  assign active = item_i.first || ((phase_q >= PhType) && (phase_q <= PhValue));
  assign rest   = $signed({2'b00, mlen_e}) - $signed({2'b00, pos_e}) - 10'sd1;

  always_comb begin
    unique case (b)
      ptp_pkg::ID_SSID:        id_attr = ptp_pkg::ATTR_SSID;
      ptp_pkg::ID_PASSWORD:    id_attr = ptp_pkg::ATTR_PASSWORD;
      ptp_pkg::ID_BSSID:       id_attr = ptp_pkg::ATTR_BSSID;
      ptp_pkg::ID_TOKEN:       id_attr = ptp_pkg::ATTR_TOKEN;
      ptp_pkg::ID_REGION_ID:   id_attr = ptp_pkg::ATTR_REGION_ID;
      ptp_pkg::ID_URL:         id_attr = ptp_pkg::ATTR_URL;
      ptp_pkg::ID_REGION_TYPE: id_attr = ptp_pkg::ATTR_REGION_TYPE;
      default:                 id_attr = ptp_pkg::ATTR_UNKNOWN;
    endcase
  end

  always_comb begin
    unique case (id_attr)
      ptp_pkg::ATTR_BSSID, ptp_pkg::ATTR_TOKEN: begin
        type_need = ptp_pkg::TYPE_BINARY;
      end
      ptp_pkg::ATTR_REGION_ID, ptp_pkg::ATTR_REGION_TYPE: begin
        type_need = ptp_pkg::TYPE_REGION;
      end
      default: type_need = ptp_pkg::TYPE_STRING;
    endcase
  end

  // Remaining-length check at the attribute byte
  always_comb begin
    unique case (id_attr)
      ptp_pkg::ATTR_BSSID: attr_bad = rest < 10'sd6;
      ptp_pkg::ATTR_TOKEN: attr_bad = rest < 10'sd3;
      ptp_pkg::ATTR_REGION_ID, ptp_pkg::ATTR_REGION_TYPE: begin
        attr_bad = rest < 10'sd1;
      end
      default: attr_bad = rest <= 10'sd3;
    endcase
  end

  // Length check at the low length byte; any nonzero high byte exceeds every limit
  always_comb begin
    unique case (attr_e)
      ptp_pkg::ATTR_SSID:     len_bad = b > SsidLim;
      ptp_pkg::ATTR_PASSWORD: len_bad = b > PassLim;
      ptp_pkg::ATTR_BSSID:    len_bad = b != ptp_pkg::BSSID_LEN;
      ptp_pkg::ATTR_TOKEN:    len_bad = b > TokenLim;
      default:                len_bad = b > UrlLim;
    endcase
    len_bad = len_bad || (vlen_e != 8'd0) || (rest < $signed({2'b00, b}));
  end

  assign vlast = ({1'b0, vcnt_e} + 9'd1) >= {1'b0, vlen_e};

  always_comb begin
    phase_d    = ph_e;
    pos_d      = pos_e + 8'd1;
    mlen_d     = mlen_e;
    etype_d    = etype_e;
    attr_d     = attr_e;
    vlen_d     = vlen_e;
    vcnt_d     = vcnt_e;
    seen_d     = seen_e;
    err        = 1'b0;
    err_status = ptp_pkg::ST_MALFORMED;
    val_out    = 1'b0;
    unique case (ph_e)
      PhType: begin
        if (rest < 10'sd1) begin
          err = 1'b1;
        end else begin
          etype_d = b;
          phase_d = PhAttr;
        end
      end
      PhAttr: begin
        if (id_attr == ptp_pkg::ATTR_UNKNOWN) begin
          err        = 1'b1;
          err_status = ptp_pkg::ST_UNKNOWN;
        end else if ((etype_e != type_need) || attr_bad) begin
          err = 1'b1;
        end else begin
          attr_d = id_attr;
          vcnt_d = '0;
          if ((id_attr == ptp_pkg::ATTR_REGION_ID) ||
              (id_attr == ptp_pkg::ATTR_REGION_TYPE)) begin
            vlen_d  = 8'd1;
            phase_d = PhValue;
          end else begin
            phase_d = PhLenHi;
          end
        end
      end
      PhLenHi: begin
        vlen_d  = b;
        phase_d = PhLenLo;
      end
      PhLenLo: begin
        if (len_bad) begin
          err = 1'b1;
        end else begin
          vlen_d = b;
          vcnt_d = '0;
          if (b == 8'd0) begin
            seen_d  = seen_e | (7'd1 << attr_e);
            phase_d = PhType;
          end else begin
            phase_d = PhValue;
          end
        end
      end
      PhValue: begin
        val_out = 1'b1;
        vcnt_d  = vcnt_e + 8'd1;
        if (vlast) begin
          seen_d  = seen_e | (7'd1 << attr_e);
          phase_d = PhType;
        end
      end
      default: begin
        phase_d = PhIdle;
      end
    endcase
    done = !err && (phase_d == PhType) && (rest <= 10'sd0);
    if (err || done) begin
      phase_d = PhIdle;
    end
  end

  // Result words
  always_comb begin
    val_res             = '0;
    val_res.kind        = ptp_pkg::KIND_VALUE;
    val_res.attribute   = attr_e;
    val_res.value_byte  = b;
    val_res.value_index = vcnt_e;
    val_res.value_last  = vlast;
    val_res.last        = !done;

    sum_res              = '0;
    sum_res.kind         = ptp_pkg::KIND_SUMMARY;
    sum_res.status       = err ? err_status : ptp_pkg::ST_OK;
    sum_res.ready_flags  = err ? seen_e : seen_d;
    sum_res.apinfo_ready = |sum_res.ready_flags[1:0];
    sum_res.last         = 1'b1;
  end

  always_comb begin
    push_o = '0;
    if (fire_i && active) begin
      if (val_out) begin
        push_o.r0  = val_res;
        push_o.r1  = sum_res;
        push_o.cnt = done ? 2'd2 : 2'd1;
      end else if (err || done) begin
        push_o.r0  = sum_res;
        push_o.cnt = 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      pos_q   <= '0;
      mlen_q  <= '0;
      etype_q <= '0;
      attr_q  <= '0;
      vlen_q  <= '0;
      vcnt_q  <= '0;
      seen_q  <= '0;
    end else if (fire_i && active) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      mlen_q  <= mlen_d;
      etype_q <= etype_d;
      attr_q  <= attr_d;
      vlen_q  <= vlen_d;
      vcnt_q  <= vcnt_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// ===== design/ptp_out_queue.sv =====
// ----------------------------------------------------------------------------
// Provisioning TLV parser result queue
// Small registered queue taking up to two results a cycle, giving one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptp_out_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ptp_pkg::push_t push_i,
  input  logic           pop_i,
  output ptp_pkg::out_t  head_o,
  output logic           avail_o,
  output logic           room2_o
);

  ptp_pkg::out_t                   mem_q [ptp_pkg::QDEPTH];
  logic [ptp_pkg::QPTR_W-1:0]      wr_q, rd_q;
  logic [ptp_pkg::QCNT_W-1:0]      cnt_q;
  logic                            pop;

  assign avail_o = cnt_q != '0;
  assign room2_o = cnt_q <= ptp_pkg::QCNT_W'(ptp_pkg::QDEPTH - 2);
  assign head_o  = mem_q[rd_q];
  assign pop     = pop_i && avail_o;

  // Payload store
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_q + ptp_pkg::QPTR_W'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + ptp_pkg::QPTR_W'(push_i.cnt);
      rd_q  <= rd_q + ptp_pkg::QPTR_W'(pop);
      cnt_q <= cnt_q + ptp_pkg::QCNT_W'(push_i.cnt) - ptp_pkg::QCNT_W'(pop);
    end
  end

endmodule

// ===== tb/tlv_result_monitor.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Provisioning TLV parser result monitor
// Watches both channels of the parser. Predicts the value and summary results
// of every accepted byte and compares each output transfer, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------

module tlv_result_monitor #(
  parameter int unsigned SSID_MAX     = 32,
  parameter int unsigned PASSWORD_MAX = 64,
  parameter int unsigned TOKEN_MAX    = 32,
  parameter int unsigned URL_MAX      = 128
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_ready_i,
  input  ptp_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_ready_i,
  input  ptp_pkg::out_t out_data_i,
  output int            fail_count_o,
  output int            pending_o,
  output int            value_count_o,
  output int            summary_count_o,
  output int            malformed_count_o,
  output int            unknown_count_o
);

  import ptp_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TYPE,
    PH_ATTR,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_VALUE
  } phase_e;

  phase_e      phase;
  logic [7:0]  byte_pos;
  logic [7:0]  msg_length;
  logic [7:0]  elem_type;
  logic [2:0]  cur_attr;
  logic [15:0] val_len;
  logic [7:0]  val_cnt;
  logic [6:0]  seen;

  // Results predicted but not yet seen on the output, oldest first
  out_t due_results[$];

  function automatic logic [2:0] attr_of_id(logic [7:0] id);
    case (id)
      ID_SSID:        return ATTR_SSID;
      ID_PASSWORD:    return ATTR_PASSWORD;
      ID_BSSID:       return ATTR_BSSID;
      ID_TOKEN:       return ATTR_TOKEN;
      ID_REGION_ID:   return ATTR_REGION_ID;
      ID_URL:         return ATTR_URL;
      ID_REGION_TYPE: return ATTR_REGION_TYPE;
      default:        return ATTR_UNKNOWN;
    endcase
  endfunction

  function automatic logic [7:0] type_for(logic [2:0] attr);
    case (attr)
      ATTR_BSSID, ATTR_TOKEN:           return TYPE_BINARY;
      ATTR_REGION_ID, ATTR_REGION_TYPE: return TYPE_REGION;
      default:                          return TYPE_STRING;
    endcase
  endfunction

  // Close the message with a summary and go idle
  task automatic push_summary(input logic [1:0] status);
    out_t r;
    r = '0;
    r.kind         = KIND_SUMMARY;
    r.status       = status;
    r.ready_flags  = seen;
    r.apinfo_ready = |seen[1:0];
    r.last         = 1'b1;
    due_results.push_back(r);
    phase = PH_IDLE;
  endtask

  task automatic parse_byte(input in_t item);
    int   rest;
    int   len;
    logic [2:0] a;
    logic bad;
    logic has_value;
    out_t v;
    has_value = 1'b0;
    v = '0;
    if (item.first) begin
      msg_length = item.msg_len;
      byte_pos   = '0;
      seen       = '0;
      elem_type  = '0;
      cur_attr   = '0;
      val_len    = '0;
      val_cnt    = '0;
      phase      = PH_TYPE;
      if (msg_length < 8'd2) begin
        push_summary(ST_MALFORMED);
        return;
      end
    end else if (phase == PH_IDLE) begin
      return;
    end

    // bytes of the message still to come after this one
    rest = int'(msg_length) - int'(byte_pos) - 1;

    case (phase)
      PH_TYPE: begin
        if (rest < 1) begin
          push_summary(ST_MALFORMED);
          return;
        end
        elem_type = item.data_byte;
        phase = PH_ATTR;
      end
      PH_ATTR: begin
        a = attr_of_id(item.data_byte);
        if (a == ATTR_UNKNOWN) begin
          push_summary(ST_UNKNOWN);
          return;
        end
        if (elem_type != type_for(a)) begin
          push_summary(ST_MALFORMED);
          return;
        end
        case (a)
          ATTR_BSSID:                       bad = rest < int'(BSSID_LEN);
          ATTR_TOKEN:                       bad = rest < 3;
          ATTR_REGION_ID, ATTR_REGION_TYPE: bad = rest < 1;
          default:                          bad = rest <= 3;
        endcase
        if (bad) begin
          push_summary(ST_MALFORMED);
          return;
        end
        cur_attr = a;
        val_cnt = '0;
        if (a == ATTR_REGION_ID || a == ATTR_REGION_TYPE) begin
          val_len = 16'd1;
          phase = PH_VALUE;
        end else begin
          phase = PH_LEN_HI;
        end
      end
      PH_LEN_HI: begin
        val_len = {item.data_byte, 8'h00};
        phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = int'({val_len[15:8], item.data_byte});
        val_len = 16'(len);
        case (cur_attr)
          ATTR_SSID:     bad = len > int'(SSID_MAX);
          ATTR_PASSWORD: bad = len > int'(PASSWORD_MAX);
          ATTR_BSSID:    bad = len != int'(BSSID_LEN);
          ATTR_TOKEN:    bad = len > int'(TOKEN_MAX);
          default:       bad = len > int'(URL_MAX);
        endcase
        if (bad || rest < len) begin
          push_summary(ST_MALFORMED);
          return;
        end
        val_cnt = '0;
        if (len == 0) begin
          seen[cur_attr] = 1'b1;
          phase = PH_TYPE;
        end else begin
          phase = PH_VALUE;
        end
      end
      default: begin
        v.kind        = KIND_VALUE;
        v.attribute   = cur_attr;
        v.value_byte  = item.data_byte;
        v.value_index = val_cnt;
        v.value_last  = (int'(val_cnt) + 1) >= int'(val_len);
        v.last        = 1'b1;
        has_value     = 1'b1;
        val_cnt       = val_cnt + 8'd1;
        if (v.value_last) begin
          seen[cur_attr] = 1'b1;
          phase = PH_TYPE;
        end
      end
    endcase

    byte_pos = byte_pos + 8'd1;
    // message ends on an element boundary: summary follows any value byte
    if (phase == PH_TYPE && rest <= 0) begin
      if (has_value) begin
        v.last = 1'b0;
        due_results.push_back(v);
      end
      push_summary(ST_OK);
    end else if (has_value) begin
      due_results.push_back(v);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count_o++;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (due_results.size() == 0) begin
      $error("result %0h arrived with nothing expected", got);
      fail_count_o++;
      return;
    end
    want = due_results.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("attribute", want.attribute, got.attribute);
    check_field("value_byte", want.value_byte, got.value_byte);
    check_field("value_index", want.value_index, got.value_index);
    check_field("value_last", want.value_last, got.value_last);
    check_field("status", want.status, got.status);
    check_field("ready_flags", want.ready_flags, got.ready_flags);
    check_field("apinfo_ready", want.apinfo_ready, got.apinfo_ready);
    check_field("last", want.last, got.last);
    if (want.kind == KIND_SUMMARY) begin
      summary_count_o++;
      if (want.status == ST_MALFORMED) malformed_count_o++;
      if (want.status == ST_UNKNOWN) unknown_count_o++;
    end else begin
      value_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase             = PH_IDLE;
      byte_pos          = '0;
      msg_length        = '0;
      elem_type         = '0;
      cur_attr          = '0;
      val_len           = '0;
      val_cnt           = '0;
      seen              = '0;
      due_results.delete();
      fail_count_o      = 0;
      value_count_o     = 0;
      summary_count_o   = 0;
      malformed_count_o = 0;
      unknown_count_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) parse_byte(in_data_i);
      if (out_valid_i && out_ready_i) check_result(out_data_i);
    end
    pending_o = due_results.size();
  end

endmodule

// ===== tb/tb_provisioning_tlv_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Provisioning TLV parser testbench
// Feeds the parser a short directed set of messages and then a long run of
// random messages, most of them well formed, the rest flawed, cut short,
// abandoned or mixed with stray bytes. A separate monitor predicts and checks
// every result; this module makes the traffic and gives the verdict.
// ----------------------------------------------------------------------------

module tb_provisioning_tlv_parser;

  import ptp_pkg::*;

  localparam int unsigned SSID_MAX     = 32;
  localparam int unsigned PASSWORD_MAX = 64;
  localparam int unsigned TOKEN_MAX    = 32;
  localparam int unsigned URL_MAX      = 128;

  // Random part stops once this many message bytes have been offered
  localparam int unsigned RANDOM_ITEMS    = 1150;
  // Cycles without any transfer before the run is called hung
  localparam int unsigned IDLE_LIMIT      = 2000;
  // Long receiver hold-off, enough to fill the result queue and stall input
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned HOLD_OFF_AT     = 8;
  // Settle time after the last result
  localparam int unsigned DRAIN_CYCLES    = 20;
  localparam int unsigned RESET_CYCLES    = 11;
  // Flipping this bit turns every known attribute id into an unknown one
  localparam logic [7:0]  ID_SCRAMBLE     = 8'h40;

  // How a random message is spoilt, if at all
  typedef enum int {
    FLAW_NONE,
    FLAW_TYPE,
    FLAW_ID,
    FLAW_OVERSIZE,
    FLAW_SHORT_LEN,
    FLAW_LONG_LEN,
    FLAW_TINY,
    FLAW_TRAILING,
    FLAW_RESTART
  } flaw_e;

  // Receiver stall patterns
  typedef enum int {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_mode_e;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int fail_count;
  int pending;
  int value_count;
  int summary_count;
  int malformed_count;
  int unknown_count;

  int bytes_sent   = 0;
  int items        = 0;
  int messages     = 0;
  int burst_left   = 0;
  int hold_offs    = 0;
  int idle_cycles  = 0;
  bit hold_off_req = 1'b0;

  logic [7:0] frame[$];

  provisioning_tlv_parser #(
    .SSID_MAX     (SSID_MAX),
    .PASSWORD_MAX (PASSWORD_MAX),
    .TOKEN_MAX    (TOKEN_MAX),
    .URL_MAX      (URL_MAX)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  tlv_result_monitor #(
    .SSID_MAX     (SSID_MAX),
    .PASSWORD_MAX (PASSWORD_MAX),
    .TOKEN_MAX    (TOKEN_MAX),
    .URL_MAX      (URL_MAX)
  ) i_monitor (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .in_data_i         (in_data),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .out_data_i        (out_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending),
    .value_count_o     (value_count),
    .summary_count_o   (summary_count),
    .malformed_count_o (malformed_count),
    .unknown_count_o   (unknown_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Value length for a length-coded attribute other than the bssid: mostly short,
  // sometimes empty or at the maximum the parser allows
  function automatic int pick_len(int unsigned max_len);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return int'(max_len);
      default: return int'($urandom_range(1, (max_len < 10) ? max_len : 10));
    endcase
  endfunction

  // Append one element to the frame: type, id, optional length, value bytes
  function automatic void add_element(logic [7:0] type_b, logic [7:0] id_b,
                                      bit has_len, int unsigned len,
                                      int unsigned nbytes);
    frame.push_back(type_b);
    frame.push_back(id_b);
    if (has_len) begin
      frame.push_back(len[15:8]);
      frame.push_back(len[7:0]);
    end
    repeat (nbytes) frame.push_back(8'($urandom));
  endfunction

  // Offer one byte and hold it until the transfer. Called at a falling edge;
  // returns at the falling edge after the transfer with valid still high, so
  // a back-to-back byte replaces the payload without a gap.
  task automatic send_byte(input logic first, input logic [7:0] len,
                           input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 6));
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid = 1'b1;
    in_data  = '{first: first, msg_len: len, data_byte: data};
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] len, input int count);
    for (int i = 0; i < count; i++) send_byte(i == 0, len, frame[i]);
    messages++;
  endtask

  // Drop valid and hold off until every expected result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic run_directed();
    // a length below two closes the message at once
    frame = '{8'h00};
    send_frame(8'd0, 1);
    // stray byte with no message open: ignored
    send_byte(1'b0, 8'hFF, 8'hFF);
    // lone region type: its value byte and the summary come together
    frame = '{TYPE_REGION, ID_REGION_TYPE, 8'hFF};
    send_frame(8'd3, 3);
    // unknown attribute id
    frame = '{TYPE_STRING, ID_SSID ^ ID_SCRAMBLE};
    send_frame(8'd2, 2);
    // token under the string type code
    frame = '{TYPE_STRING, ID_TOKEN};
    send_frame(8'd2, 2);
    // region id, then a type byte that is the last byte of the message
    frame = '{TYPE_REGION, ID_REGION_ID, 8'h80, TYPE_STRING};
    send_frame(8'd4, 4);
    // ssid left open, abandoned by a new message carrying a bssid
    frame = '{TYPE_STRING, ID_SSID, 8'h00};
    send_frame(8'd255, 3);
    frame = '{TYPE_BINARY, ID_BSSID, 8'h00, BSSID_LEN,
              8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'hFE};
    send_frame(8'd10, 10);
  endtask

  task automatic send_random_message();
    flaw_e      flaw;
    int         n_elem;
    int         bad_elem;
    int         vlen;
    int         lim;
    int         nbytes;
    int         sent;
    bit         has_len;
    logic [2:0] attr;
    logic [7:0] type_b;
    logic [7:0] id_b;
    logic [7:0] len_field;
    frame.delete();
    flaw = ($urandom_range(0, 99) < 75) ? FLAW_NONE
                                        : flaw_e'($urandom_range(1, 8));
    n_elem   = $urandom_range(1, 6);
    bad_elem = $urandom_range(0, n_elem - 1);
    for (int e = 0; e < n_elem; e++) begin
      attr    = 3'($urandom_range(0, 6));
      has_len = 1'b1;
      lim     = 0;
      case (attr)
        ATTR_SSID: begin
          type_b = TYPE_STRING;
          id_b   = ID_SSID;
          lim    = SSID_MAX;
        end
        ATTR_PASSWORD: begin
          type_b = TYPE_STRING;
          id_b   = ID_PASSWORD;
          lim    = PASSWORD_MAX;
        end
        ATTR_BSSID: begin
          type_b = TYPE_BINARY;
          id_b   = ID_BSSID;
          lim    = BSSID_LEN;
        end
        ATTR_TOKEN: begin
          type_b = TYPE_BINARY;
          id_b   = ID_TOKEN;
          lim    = TOKEN_MAX;
        end
        ATTR_URL: begin
          type_b = TYPE_STRING;
          id_b   = ID_URL;
          lim    = URL_MAX;
        end
        ATTR_REGION_ID: begin
          type_b  = TYPE_REGION;
          id_b    = ID_REGION_ID;
          has_len = 1'b0;
        end
        default: begin
          type_b  = TYPE_REGION;
          id_b    = ID_REGION_TYPE;
          has_len = 1'b0;
        end
      endcase
      if (!has_len) vlen = 1;
      else if (attr == ATTR_BSSID) vlen = BSSID_LEN;
      else vlen = pick_len(lim);
      nbytes = vlen;
      // spoil one element; the parser drops the rest of the message anyway
      if (e == bad_elem) begin
        case (flaw)
          FLAW_TYPE: type_b = type_b ^ 8'($urandom_range(1, 255));
          FLAW_ID: id_b = ($urandom_range(0, 1) != 0) ? (id_b ^ ID_SCRAMBLE)
                                                      : 8'($urandom);
          FLAW_OVERSIZE: begin
            if (has_len) begin
              vlen   = ($urandom_range(0, 1) != 0) ? lim + 1
                                                   : int'($urandom_range(256, 65535));
              nbytes = 2;
            end
          end
          default: ;
        endcase
      end
      if (frame.size() + 4 + nbytes > 250) break;
      add_element(type_b, id_b, has_len, vlen, nbytes);
    end

    len_field = 8'(frame.size());
    case (flaw)
      FLAW_SHORT_LEN: len_field = 8'($urandom_range(2, frame.size() - 1));
      FLAW_LONG_LEN:  len_field = 8'($urandom_range(frame.size() + 1, 255));
      FLAW_TINY:      len_field = 8'($urandom_range(0, 1));
      FLAW_TRAILING: begin
        frame.push_back(TYPE_STRING);
        len_field = 8'(frame.size());
      end
      default: ;
    endcase
    // an abandoned message is cut short and the next one restarts the parser
    sent = (flaw == FLAW_RESTART) ? int'($urandom_range(1, frame.size() - 1))
                                  : frame.size();
    send_frame(len_field, sent);
    items += sent;
  endtask

  // Receiver: stall patterns change every stretch; a requested hold-off
  // keeps ready low for a long, counted stretch while the sender carries on
  initial begin : receiver
    int       stretch;
    rx_mode_e mode;
    out_ready = 1'b0;
    stretch   = 0;
    mode      = RX_FREE;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready = 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        hold_offs++;
      end
      if (stretch == 0) begin
        stretch = $urandom_range(16, 160);
        mode    = rx_mode_e'($urandom_range(0, 3));
      end
      stretch--;
      case (mode)
        RX_FREE:  out_ready = 1'b1;
        RX_LIGHT: out_ready = $urandom_range(0, 3) != 0;
        RX_HEAVY: out_ready = $urandom_range(0, 3) == 0;
        default:  out_ready = (stretch % 4) == 0;
      endcase
    end
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int random_msgs;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    random_msgs = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    run_directed();
    drain_results();

    while (items < RANDOM_ITEMS) begin
      // stray bytes between messages; parsed only if a message is left open
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) send_byte(1'b0, 8'($urandom), 8'($urandom));
      end
      // ask for one long output hold-off while input keeps flowing
      if (random_msgs == HOLD_OFF_AT) hold_off_req = 1'b1;
      // now and then pause input until every result is back
      if (random_msgs % 16 == 15) drain_results();
      send_random_message();
      random_msgs++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d value bytes and %0d summaries (%0d malformed, %0d unknown id)",
             value_count, summary_count, malformed_count, unknown_count);
    $display("from %0d accepted bytes in %0d messages, with %0d long output hold-offs",
             bytes_sent, messages, hold_offs);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
